// ===== rtl/llrb_pkg.sv =====
// ----------------------------------------------------------------------------
// llrb_pkg
// Shared constants, types and helpers of the last-lines ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package llrb_pkg;

   localparam int LINE_SLOTS   = 128;
   localparam int MAX_LINE     = 128;
   localparam int TAIL_DEFAULT = 10;

   localparam int SLOT_W     = $clog2(LINE_SLOTS);
   localparam int LINE_W     = $clog2(MAX_LINE);
   localparam int CNT_W      = $clog2(LINE_SLOTS + 1);
   localparam int TAIL_W     = (CNT_W > 8) ? CNT_W : 8;
   localparam int TEXT_DEPTH = LINE_SLOTS * MAX_LINE;
   localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
   localparam int SUM_W      = SLOT_W + 2;

   localparam logic [7:0] NEWLINE = 8'd10;

   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_FETCH,
      ST_READ
   } state_type;

   typedef struct packed {
      logic               we;
      logic [TEXT_AW-1:0] waddr;
      logic [7:0]         wdata;
      logic [TEXT_AW-1:0] raddr;
   } text_port_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] waddr;
      logic [LINE_W-1:0] wdata;
      logic [SLOT_W-1:0] raddr;
   } len_port_type;

   typedef struct packed {
      logic       strobe;
      logic [7:0] out_byte;
      logic       end_of_line;
      logic       end_of_tail;
      logic       empty_res;
   } rsp_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] nxt;
      nxt = (slot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : slot + 1'b1;
      return nxt;
   endfunction

   function automatic logic [TEXT_AW-1:0] text_addr(input logic [SLOT_W-1:0] slot,
                                                    input logic [LINE_W-1:0] offset);
      logic [TEXT_AW-1:0] addr;
      addr = TEXT_AW'(slot) * TEXT_AW'(MAX_LINE) + TEXT_AW'(offset);
      return addr;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/llrb_ram.sv =====
// ----------------------------------------------------------------------------
// llrb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module llrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/llrb_seq.sv =====
// ----------------------------------------------------------------------------
// llrb_seq
// Line ring pointers and transaction sequencer: fills line slots, commits
// lines, and walks the retained tail through the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module llrb_seq import llrb_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_type,
   input  wire logic [7:0]        data_byte,
   input  wire logic [TAIL_W-1:0] tail,
   input  wire logic [7:0]        text_rdata,
   input  wire logic [LINE_W-1:0] len_rdata,
   output logic                   busy,
   output text_port_type          text_port,
   output len_port_type           len_port,
   output rsp_type                rsp
);

   state_type         state_ff, state_in;
   logic [SLOT_W-1:0] write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   logic [LINE_W-1:0] partial_ff, partial_in;
   logic              reading_ff, reading_in;
   logic [SLOT_W-1:0] read_slot_ff, read_slot_in;
   logic [LINE_W-1:0] read_offset_ff, read_offset_in;
   logic [CNT_W-1:0]  lines_left_ff, lines_left_in;
   rsp_type           rsp_ff, rsp_in;

   logic [LINE_W-1:0] partial_plus;
   logic [CNT_W-1:0]  stored_next;
   logic [CNT_W-1:0]  tail_n;
   logic [SUM_W-1:0]  slot_sum;
   logic              eol;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_slot_ff  <= '0;
         stored_ff      <= '0;
         partial_ff     <= '0;
         reading_ff     <= 1'b0;
         read_slot_ff   <= '0;
         read_offset_ff <= '0;
         lines_left_ff  <= '0;
         rsp_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         write_slot_ff  <= write_slot_in;
         stored_ff      <= stored_in;
         partial_ff     <= partial_in;
         reading_ff     <= reading_in;
         read_slot_ff   <= read_slot_in;
         read_offset_ff <= read_offset_in;
         lines_left_ff  <= lines_left_in;
         rsp_ff         <= rsp_in;
      end
   end

   always_comb begin
      partial_plus = partial_ff + 1'b1;
      stored_next  = (stored_ff == CNT_W'(LINE_SLOTS)) ? stored_ff : stored_ff + 1'b1;
      tail_n       = (TAIL_W'(stored_ff) < tail) ? stored_ff : CNT_W'(tail);
      slot_sum     = SUM_W'(write_slot_ff) + SUM_W'(LINE_SLOTS) - SUM_W'(tail_n);
      if (slot_sum >= SUM_W'(LINE_SLOTS)) begin
         slot_sum = slot_sum - SUM_W'(LINE_SLOTS);
      end
      eol = ((LINE_W + 1)'(read_offset_ff) + 1'b1) >= (LINE_W + 1)'(len_rdata);

      state_in       = state_ff;
      write_slot_in  = write_slot_ff;
      stored_in      = stored_ff;
      partial_in     = partial_ff;
      reading_in     = reading_ff;
      read_slot_in   = read_slot_ff;
      read_offset_in = read_offset_ff;
      lines_left_in  = lines_left_ff;
      rsp_in         = '0;

      text_port.we    = 1'b0;
      text_port.waddr = text_addr(write_slot_ff, partial_ff);
      text_port.wdata = data_byte;
      text_port.raddr = text_addr(read_slot_ff, read_offset_ff);
      len_port.we     = 1'b0;
      len_port.waddr  = write_slot_ff;
      len_port.wdata  = partial_plus;
      len_port.raddr  = read_slot_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_DATA) begin
                  if (!reading_ff) begin
                     text_port.we = 1'b1;
                     if (data_byte == NEWLINE || partial_plus >= LINE_W'(MAX_LINE - 1)) begin
                        len_port.we   = 1'b1;
                        write_slot_in = slot_inc(write_slot_ff);
                        stored_in     = stored_next;
                        partial_in    = '0;
                     end else begin
                        partial_in = partial_plus;
                     end
                  end
               end else if (!reading_ff) begin
                  // commit the pending partial line
                  if (partial_ff != '0) begin
                     len_port.we    = 1'b1;
                     len_port.wdata = partial_ff;
                     write_slot_in  = slot_inc(write_slot_ff);
                     stored_in      = stored_next;
                     partial_in     = '0;
                  end
                  state_in = ST_SETUP;
               end else if (lines_left_ff == '0) begin
                  rsp_in.strobe    = 1'b1;
                  rsp_in.empty_res = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_SETUP: begin
            lines_left_in  = tail_n;
            read_slot_in   = SLOT_W'(slot_sum);
            read_offset_in = '0;
            reading_in     = 1'b1;
            if (tail_n == '0) begin
               rsp_in.strobe    = 1'b1;
               rsp_in.empty_res = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            rsp_in.strobe      = 1'b1;
            rsp_in.out_byte    = text_rdata;
            rsp_in.end_of_line = eol;
            rsp_in.end_of_tail = eol && (lines_left_ff == CNT_W'(1));
            if (eol) begin
               read_offset_in = '0;
               read_slot_in   = slot_inc(read_slot_ff);
               lines_left_in  = lines_left_ff - 1'b1;
            end else begin
               read_offset_in = read_offset_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/last_lines_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// last_lines_ring_buffer
// Keeps the most recent lines of a text byte stream and plays back the tail.
// ----------------------------------------------------------------------------
// A text-byte transaction never raises busy. The first read transaction
// commits the open line, sizes the tail and fetches the first byte: busy
// stays high through the setup, fetch and read states, and the result
// appears in the same cycle that busy falls. When no line is stored, the
// first read raises busy for the setup state only and answers empty as
// busy falls. Each later read transaction raises busy for the read state
// only, and its result appears as busy falls; a read past the end of the
// tail answers empty on the cycle after acceptance. Results carry no
// back-pressure: rsp_strobe marks each one for a single cycle and the
// receiver must take it then.
`default_nettype none

module last_lines_ring_buffer import llrb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_type,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_strobe,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_end_of_line,
   output logic            rsp_end_of_tail,
   output logic            rsp_empty_res,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   logic [TAIL_W-1:0] tail_ff, tail_in;
   text_port_type     text_port;
   len_port_type      len_port;
   logic [7:0]        text_rdata;
   logic [LINE_W-1:0] len_rdata;
   rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= TAIL_W'(TAIL_DEFAULT);
      end else begin
         tail_ff <= tail_in;
      end
   end

   always_comb begin
      tail_in = tail_ff;
      if (csr_we) begin
         if (csr_wdata == 8'd0 || TAIL_W'(csr_wdata) > TAIL_W'(LINE_SLOTS)) begin
            tail_in = TAIL_W'(LINE_SLOTS);
         end else begin
            tail_in = TAIL_W'(csr_wdata);
         end
      end
   end

   llrb_ram #(
      .WIDTH (8),
      .DEPTH (TEXT_DEPTH)
   ) u_text_ram (
      .clock (clock),
      .we    (text_port.we),
      .waddr (text_port.waddr),
      .wdata (text_port.wdata),
      .raddr (text_port.raddr),
      .rdata (text_rdata)
   );

   llrb_ram #(
      .WIDTH (LINE_W),
      .DEPTH (LINE_SLOTS)
   ) u_len_ram (
      .clock (clock),
      .we    (len_port.we),
      .waddr (len_port.waddr),
      .wdata (len_port.wdata),
      .raddr (len_port.raddr),
      .rdata (len_rdata)
   );

   llrb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .data_byte  (req_data_byte),
      .tail       (tail_ff),
      .text_rdata (text_rdata),
      .len_rdata  (len_rdata),
      .busy       (busy),
      .text_port  (text_port),
      .len_port   (len_port),
      .rsp        (rsp)
   );

   assign rsp_strobe      = rsp.strobe;
   assign rsp_out_byte    = rsp.out_byte;
   assign rsp_end_of_line = rsp.end_of_line;
   assign rsp_end_of_tail = rsp.end_of_tail;
   assign rsp_empty_res   = rsp.empty_res;

endmodule

`default_nettype wire
